// ----- hdl/rational_add_reduce_assert.svh -----
// Assertion macros for the rational add/reduce back end.
`ifndef RATIONAL_ADD_REDUCE_ASSERT_SVH
`define RATIONAL_ADD_REDUCE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked only while out of reset
`define RAR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included
`define RAR_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`else

`define RAR_ASSERT(label, prop, msg)

`define RAR_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ----- hdl/rar_pkg.sv -----
// Package: widths, queue entry type and back-end state codes for rational add/reduce.
`timescale 1ns / 1ps

package rar_pkg;

   localparam int NumWidth          = 16;  // input numerators, signed
   localparam int InDenWidth        = 15;  // input denominators
   localparam int SumWidth          = 32;  // unreduced sum numerator, signed
   localparam int DenWidth          = 30;  // product denominator
   localparam int MagWidth          = 31;  // magnitude of the sum numerator
   localparam int CntWidth          = $clog2(MagWidth);
   localparam int ShiftWidth        = $clog2(DenWidth);
   localparam int QueueDepthDefault = 2;

   // One unreduced fraction handed from front end to back end
   typedef struct packed {
      logic [SumWidth-1:0] sum;
      logic [DenWidth-1:0] den;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GCD,
      ST_DIV_NUM,
      ST_DIV_DEN,
      ST_WRITE
   } back_state_type;

endpackage

// ----- hdl/rational_add_reduce.sv -----
// Top level: adds two fractions and reduces the sum to lowest terms.
//
//   channel | ports             | payload
//   --------+-------------------+----------------------------------------------
//   request | req_valid/ready   | left/right numerator (s16), denominator (u15)
//   result  | rsp_valid/ready   | sum_numerator (s32), sum_denominator (u30)
//
// Front end takes one transaction per cycle into a product stage and a queue,
// as long as the product stage is empty or can pass its entry to the queue.
// Back end handles one fraction at a time: binary GCD, then two divisions on
// one shared divider. A zero sum skips GCD and divisions.
// Synchronous active-high reset clears all control state; no clearing pass.
// A stalled result holds in the output register while the queue keeps filling.
`timescale 1ns / 1ps

module rational_add_reduce import rar_pkg::*; #(
   parameter int QueueDepth = QueueDepthDefault
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [NumWidth-1:0]   req_left_numerator,
   input  logic        [InDenWidth-1:0] req_left_denominator,
   input  logic signed [NumWidth-1:0]   req_right_numerator,
   input  logic        [InDenWidth-1:0] req_right_denominator,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [SumWidth-1:0]   rsp_sum_numerator,
   output logic        [DenWidth-1:0]   rsp_sum_denominator
);

   logic    push_valid, push_ready;
   job_type push_data;
   logic    pop_valid, pop_ready;
   job_type pop_data;

   rar_front u_front (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_left_numerator    (req_left_numerator),
      .req_left_denominator  (req_left_denominator),
      .req_right_numerator   (req_right_numerator),
      .req_right_denominator (req_right_denominator),
      .push_valid            (push_valid),
      .push_ready            (push_ready),
      .push_data             (push_data)
   );

   rar_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   rar_back u_back (
      .clock               (clock),
      .reset               (reset),
      .pop_valid           (pop_valid),
      .pop_ready           (pop_ready),
      .pop_data            (pop_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_sum_numerator   (rsp_sum_numerator),
      .rsp_sum_denominator (rsp_sum_denominator)
   );

endmodule

// ----- hdl/rar_front.sv -----
// Front end: takes a request, forms cross products and the unreduced sum.
`timescale 1ns / 1ps

module rar_front import rar_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [NumWidth-1:0]   req_left_numerator,
   input  logic        [InDenWidth-1:0] req_left_denominator,
   input  logic signed [NumWidth-1:0]   req_right_numerator,
   input  logic        [InDenWidth-1:0] req_right_denominator,
   output logic                         push_valid,
   input  logic                         push_ready,
   output job_type                      push_data
);

   logic                        stage_vld_ff, stage_vld_in;
   logic signed [SumWidth-1:0]  prod_a_ff, prod_a_in;
   logic signed [SumWidth-1:0]  prod_b_ff, prod_b_in;
   logic        [DenWidth-1:0]  den_ff, den_in;
   logic        [InDenWidth-1:0] ld_eff, rd_eff;
   logic signed [SumWidth-1:0]  sum;

   // A zero denominator reads as one
   assign ld_eff = (req_left_denominator == '0) ? InDenWidth'(1) : req_left_denominator;
   assign rd_eff = (req_right_denominator == '0) ? InDenWidth'(1) : req_right_denominator;

   assign req_ready = !stage_vld_ff || push_ready;

   // Product stage
   always_comb begin
      stage_vld_in = stage_vld_ff;
      prod_a_in    = prod_a_ff;
      prod_b_in    = prod_b_ff;
      den_in       = den_ff;
      if (req_valid && req_ready) begin
         stage_vld_in = 1'b1;
         prod_a_in    = SumWidth'(req_left_numerator) * SumWidth'($signed({1'b0, rd_eff}));
         prod_b_in    = SumWidth'(req_right_numerator) * SumWidth'($signed({1'b0, ld_eff}));
         den_in       = DenWidth'(ld_eff) * DenWidth'(rd_eff);
      end else if (push_ready) begin
         stage_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= 1'b0;
      end else begin
         stage_vld_ff <= stage_vld_in;
      end
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
      den_ff    <= den_in;
   end

   // Sum cannot overflow 32 bits for the given input ranges
   assign sum            = prod_a_ff + prod_b_ff;
   assign push_valid     = stage_vld_ff;
   assign push_data.sum  = sum;
   assign push_data.den  = den_ff;

endmodule

// ----- hdl/rar_queue.sv -----
// Short queue that decouples the front end from the reduction back end.
`timescale 1ns / 1ps

module rar_queue import rar_pkg::*; #(
   parameter int Depth = QueueDepthDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_data
);

   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);

   job_type                 entry_ff [Depth];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]   count_ff, count_in;
   logic                    do_push, do_pop;

   assign push_ready = (count_ff != CountWidth'(Depth));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hdl/rar_back.sv -----
// Back end: binary GCD, two exact divisions on a shared divider, result register.
`timescale 1ns / 1ps
`include "rational_add_reduce_assert.svh"

module rar_back import rar_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       pop_valid,
   output logic                       pop_ready,
   input  job_type                    pop_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SumWidth-1:0] rsp_sum_numerator,
   output logic        [DenWidth-1:0] rsp_sum_denominator
);

   back_state_type            state_ff, state_in;
   logic                      neg_ff, neg_in;
   logic [MagWidth-1:0]       mag_ff, mag_in;
   logic [DenWidth-1:0]       den_ff, den_in;
   logic [MagWidth-1:0]       a_ff, a_in;
   logic [MagWidth-1:0]       b_ff, b_in;
   logic [ShiftWidth-1:0]     k_ff, k_in;
   logic [DenWidth-1:0]       g_ff, g_in;
   logic [MagWidth-1:0]       q_ff, q_in;
   logic [DenWidth-1:0]       rem_ff, rem_in;
   logic [CntWidth-1:0]       cnt_ff, cnt_in;
   logic [MagWidth-1:0]       num_res_ff, num_res_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [SumWidth-1:0]       rsp_num_ff, rsp_num_in;
   logic [DenWidth-1:0]       rsp_den_ff, rsp_den_in;

   logic [SumWidth-1:0]       job_abs;
   logic [MagWidth:0]         rem_sh, rem_sub;
   logic                      div_ge, div_last, out_free;
   logic [DenWidth-1:0]       rem_nx;
   logic [MagWidth-1:0]       q_nx, g_full;
   logic [SumWidth-1:0]       num_ext;

   // Shared restoring divider step: one quotient bit per cycle
   assign rem_sh   = {1'b0, rem_ff, q_ff[MagWidth-1]};
   assign rem_sub  = rem_sh - {2'b00, g_ff};
   assign div_ge   = (rem_sh >= {2'b00, g_ff});
   assign rem_nx   = div_ge ? rem_sub[DenWidth-1:0] : rem_sh[DenWidth-1:0];
   assign q_nx     = {q_ff[MagWidth-2:0], div_ge};
   assign div_last = (cnt_ff == CntWidth'(MagWidth - 1));

   assign job_abs  = pop_data.sum[SumWidth-1] ? (~pop_data.sum + 1'b1) : pop_data.sum;
   assign g_full   = a_ff << k_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign num_ext  = {1'b0, num_res_ff};

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      den_in       = den_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      k_in         = k_ff;
      g_in         = g_ff;
      q_in         = q_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      num_res_in   = num_res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;
      pop_ready    = 1'b0;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               neg_in = pop_data.sum[SumWidth-1];
               mag_in = job_abs[MagWidth-1:0];
               den_in = pop_data.den;
               a_in   = job_abs[MagWidth-1:0];
               b_in   = {1'b0, pop_data.den};
               k_in   = '0;
               if (pop_data.sum == '0) begin
                  // zero sum reduces to 0/1
                  neg_in     = 1'b0;
                  num_res_in = '0;
                  q_in       = MagWidth'(1);
                  state_in   = ST_WRITE;
               end else begin
                  state_in = ST_GCD;
               end
            end
         end
         ST_GCD: begin
            if (a_ff == b_ff) begin
               g_in     = g_full[DenWidth-1:0];
               q_in     = mag_ff;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIV_NUM;
            end else if (!a_ff[0] && !b_ff[0]) begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else if (a_ff > b_ff) begin
               a_in = (a_ff - b_ff) >> 1;
            end else begin
               b_in = (b_ff - a_ff) >> 1;
            end
         end
         ST_DIV_NUM: begin
            q_in   = q_nx;
            rem_in = rem_nx;
            cnt_in = cnt_ff + 1'b1;
            if (div_last) begin
               num_res_in = q_nx;
               q_in       = {1'b0, den_ff};
               rem_in     = '0;
               cnt_in     = '0;
               state_in   = ST_DIV_DEN;
            end
         end
         ST_DIV_DEN: begin
            q_in   = q_nx;
            rem_in = rem_nx;
            cnt_in = cnt_ff + 1'b1;
            if (div_last) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = neg_ff ? (~num_ext + 1'b1) : num_ext;
               rsp_den_in   = q_ff[DenWidth-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff     <= neg_in;
      mag_ff     <= mag_in;
      den_ff     <= den_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      k_ff       <= k_in;
      g_ff       <= g_in;
      q_ff       <= q_in;
      rem_ff     <= rem_in;
      cnt_ff     <= cnt_in;
      num_res_ff <= num_res_in;
      rsp_num_ff <= rsp_num_in;
      rsp_den_ff <= rsp_den_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_sum_numerator   = $signed(rsp_num_ff);
   assign rsp_sum_denominator = rsp_den_ff;

   // GCD operands never reach zero, divisions by the GCD leave no remainder
   `RAR_ASSERT(a_gcd_nonzero, (state_ff == ST_GCD) |-> (a_ff != '0 && b_ff != '0), "gcd operand zero")
   `RAR_ASSERT(a_div_exact, ((state_ff == ST_DIV_NUM || state_ff == ST_DIV_DEN) && div_last) |-> (rem_nx == '0), "inexact division by gcd")
   `RAR_ASSERT(a_den_nonzero, rsp_valid_ff |-> (rsp_den_ff != '0), "zero result denominator")

endmodule
